FILE: design/lome_pkg.sv
// Shared types, codes and defaults for the limit order matching engine.
package lome_pkg;

  localparam int DefOrderSlots = 64;

  localparam logic [2:0] StatusDone    = 3'd0;
  localparam logic [2:0] StatusRested  = 3'd1;
  localparam logic [2:0] StatusCancel  = 3'd2;
  localparam logic [2:0] StatusUnknown = 3'd3;
  localparam logic [2:0] StatusFull    = 3'd4;

  localparam logic OpAdd    = 1'b0;
  localparam logic OpCancel = 1'b1;

  typedef struct packed {
    logic        is_buy;
    logic [31:0] order_id;
    logic [31:0] price;
    logic [31:0] remaining;
    logic [31:0] sequence_no;
  } slot_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DECIDE = 4'b0100,
    ST_TRADE  = 4'b1000
  } state_e;

endpackage

FILE: design/lome_store.sv
// Slot store: entry memory with registered read and per-slot valid flags.
module lome_store #(
  parameter int OrderSlots = lome_pkg::DefOrderSlots,
  localparam int IW = (OrderSlots > 1) ? $clog2(OrderSlots) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [IW-1:0]         rd_idx_i,
  output lome_pkg::slot_t       rd_data_o,
  input  logic                  wr_en_i,
  input  logic                  set_vld_i,
  input  logic                  clr_vld_i,
  input  logic [IW-1:0]         wr_idx_i,
  input  lome_pkg::slot_t       wr_data_i,
  output logic [OrderSlots-1:0] vld_o
);
  import lome_pkg::*;

  slot_t                  mem [OrderSlots];
  logic [OrderSlots-1:0]  vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_data_i;
    end
    rd_data_o <= mem[rd_idx_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (set_vld_i) begin
      vld_q[wr_idx_i] <= 1'b1;
    end else if (clr_vld_i) begin
      vld_q[wr_idx_i] <= 1'b0;
    end
  end

  assign vld_o = vld_q;

endmodule

FILE: design/limit_order_matching_engine.sv
// Top level of the limit order matching engine: sequencer, slot scan and result register.
// Each scan of the slot store reads one slot per cycle through one compare unit. A cancel
// takes one scan; an add takes one scan plus one more after each trade that leaves quantity
// over, and orders are handled one at a time.
// Reset clears all slot valid flags, the sequence counter and the trade id counter at once.
module limit_order_matching_engine #(
  parameter int OrderSlots = lome_pkg::DefOrderSlots,
  localparam int IW = (OrderSlots > 1) ? $clog2(OrderSlots) : 1,
  localparam int CW = $clog2(OrderSlots + 1)
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [31:0] order_id_i,
  input  logic        buy_side_i,
  input  logic        is_market_i,
  input  logic [31:0] limit_price_i,
  input  logic [31:0] quantity_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic        trade_valid_o,
  output logic [63:0] trade_id_o,
  output logic [31:0] trade_price_o,
  output logic [31:0] trade_qty_o,
  output logic [31:0] buyer_id_o,
  output logic [31:0] seller_id_o,
  output logic [31:0] left_qty_o,
  output logic        last_o
);
  import lome_pkg::*;

  state_e state_q, state_d;
  logic        op_q, buy_q, mkt_q;
  logic [31:0] id_q, lim_q, rem_q, rem_d, seq_q, seq_d;
  logic [63:0] tid_q, tid_d;
  logic [CW-1:0] n_q, n_d, cnt_q, cnt_d;
  logic        rv_q, rv_d;
  logic [IW-1:0] ridx_q, ridx_d;
  logic        bf_q, bf_d, ff_q, ff_d;
  logic [IW-1:0] best_idx_q, best_idx_d, free_idx_q, free_idx_d;
  slot_t       best_q, best_d;
  logic [31:0] best_age_q, best_age_d;
  logic        pend_q, pend_d;
  logic [63:0] p_tid_q, p_tid_d;
  logic [31:0] p_price_q, p_price_d, p_qty_q, p_qty_d, p_buyer_q, p_buyer_d;
  logic [31:0] p_seller_q, p_seller_d, p_left_q, p_left_d;

  logic        ov_q, ov_d, otv_q, otv_d, olast_q, olast_d;
  logic [2:0]  ost_q, ost_d;
  logic [63:0] otid_q, otid_d;
  logic [31:0] oprice_q, oprice_d, oqty_q, oqty_d, obuy_q, obuy_d;
  logic [31:0] osell_q, osell_d, oleft_q, oleft_d;

  logic [IW-1:0]         rd_idx, wr_idx;
  slot_t                 rd_data, wr_data;
  logic                  wr_en, set_vld, clr_vld;
  logic [OrderSlots-1:0] vld;

  logic        in_xfer, out_free, cand, better, crosses, rest;
  logic [31:0] age, fill, slot_left, rem_left;
  logic [2:0]  fin_status;

  lome_store #(.OrderSlots(OrderSlots)) u_store (
    .clk_i, .rst_ni,
    .rd_idx_i (rd_idx),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .set_vld_i(set_vld),
    .clr_vld_i(clr_vld),
    .wr_idx_i (wr_idx),
    .wr_data_i(wr_data),
    .vld_o    (vld)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !ov_q || out_ready_i;
  assign rd_idx     = cnt_q[IW-1:0];

  assign age = seq_q - rd_data.sequence_no;
  always_comb begin
    if (op_q == OpCancel) begin
      cand   = vld[ridx_q] && (rd_data.order_id == id_q);
      better = !bf_q || (age > best_age_q);
    end else begin
      cand = vld[ridx_q] && (rd_data.is_buy == !buy_q);
      if (!bf_q) begin
        better = 1'b1;
      end else if (rd_data.price != best_q.price) begin
        better = buy_q ? (rd_data.price < best_q.price) : (rd_data.price > best_q.price);
      end else begin
        better = age > best_age_q;
      end
    end
  end

  assign crosses = bf_q && (rem_q != '0) && (n_q < CW'(OrderSlots)) &&
                   (mkt_q || (buy_q ? (lim_q >= best_q.price) : (lim_q <= best_q.price)));
  assign rest    = (rem_q != '0) && !mkt_q;
  assign fin_status = !rest ? StatusDone : (ff_q ? StatusRested : StatusFull);

  assign fill      = (rem_q < best_q.remaining) ? rem_q : best_q.remaining;
  assign slot_left = best_q.remaining - fill;
  assign rem_left  = rem_q - fill;

  always_comb begin
    state_d = state_q;
    rem_d = rem_q; seq_d = seq_q; tid_d = tid_q; n_d = n_q;
    cnt_d = cnt_q; rv_d = 1'b0; ridx_d = ridx_q;
    bf_d = bf_q; ff_d = ff_q; best_idx_d = best_idx_q; free_idx_d = free_idx_q;
    best_d = best_q; best_age_d = best_age_q;
    pend_d = pend_q; p_tid_d = p_tid_q; p_price_d = p_price_q; p_qty_d = p_qty_q;
    p_buyer_d = p_buyer_q; p_seller_d = p_seller_q; p_left_d = p_left_q;
    ov_d = ov_q && !out_ready_i;
    otv_d = otv_q; olast_d = olast_q; ost_d = ost_q; otid_d = otid_q;
    oprice_d = oprice_q; oqty_d = oqty_q; obuy_d = obuy_q; osell_d = osell_q;
    oleft_d = oleft_q;
    wr_en = 1'b0; set_vld = 1'b0; clr_vld = 1'b0;
    wr_idx = best_idx_q; wr_data = best_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          rem_d  = (op_i == OpAdd) ? quantity_i : '0;
          seq_d  = (op_i == OpAdd) ? seq_q + 32'd1 : seq_q;
          n_d    = '0;
          pend_d = 1'b0;
          cnt_d  = '0; bf_d = 1'b0; ff_d = 1'b0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_q < CW'(OrderSlots)) begin
          rv_d   = 1'b1;
          ridx_d = cnt_q[IW-1:0];
          cnt_d  = cnt_q + CW'(1);
        end
        if (rv_q) begin
          if (cand && better) begin
            bf_d = 1'b1; best_idx_d = ridx_q; best_d = rd_data; best_age_d = age;
          end
          if (!vld[ridx_q] && !ff_q) begin
            ff_d = 1'b1; free_idx_d = ridx_q;
          end
          if (ridx_q == IW'(OrderSlots - 1)) begin
            state_d = ST_DECIDE;
          end
        end
      end
      ST_DECIDE: begin
        if (op_q == OpCancel) begin
          if (out_free) begin
            clr_vld = bf_q;
            ov_d = 1'b1; otv_d = 1'b0; olast_d = 1'b1;
            ost_d = bf_q ? StatusCancel : StatusUnknown;
            otid_d = '0; oprice_d = '0; oqty_d = '0; obuy_d = '0; osell_d = '0;
            oleft_d = '0;
            state_d = ST_IDLE;
          end
        end else if (crosses && !pend_q) begin
          state_d = ST_TRADE;
        end else if (out_free) begin
          ov_d = 1'b1; otv_d = pend_q;
          otid_d = pend_q ? p_tid_q : '0;
          oprice_d = pend_q ? p_price_q : '0;
          oqty_d = pend_q ? p_qty_q : '0;
          obuy_d = pend_q ? p_buyer_q : '0;
          osell_d = pend_q ? p_seller_q : '0;
          oleft_d = pend_q ? p_left_q : rem_q;
          if (crosses) begin
            ost_d = StatusDone; olast_d = 1'b0;
            state_d = ST_TRADE;
          end else begin
            ost_d = fin_status; olast_d = 1'b1;
            if (rest && ff_q) begin
              wr_en = 1'b1; set_vld = 1'b1; wr_idx = free_idx_q;
              wr_data.is_buy = buy_q; wr_data.order_id = id_q; wr_data.price = lim_q;
              wr_data.remaining = rem_q; wr_data.sequence_no = seq_q;
            end
            state_d = ST_IDLE;
          end
        end
      end
      ST_TRADE: begin
        wr_en = 1'b1;
        wr_data.remaining = slot_left;
        clr_vld = (slot_left == '0);
        pend_d = 1'b1;
        p_tid_d = tid_q; p_price_d = best_q.price; p_qty_d = fill;
        p_buyer_d = buy_q ? id_q : best_q.order_id;
        p_seller_d = buy_q ? best_q.order_id : id_q;
        p_left_d = rem_left;
        tid_d = tid_q + 64'd1;
        n_d = n_q + CW'(1);
        rem_d = rem_left;
        cnt_d = '0; bf_d = 1'b0; ff_d = 1'b0;
        state_d = (rem_left != '0) ? ST_SCAN : ST_DECIDE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      seq_q <= '0; tid_q <= '0; n_q <= '0; cnt_q <= '0; rv_q <= 1'b0;
      bf_q <= 1'b0; ff_q <= 1'b0; pend_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      seq_q <= seq_d; tid_q <= tid_d; n_q <= n_d; cnt_q <= cnt_d; rv_q <= rv_d;
      bf_q <= bf_d; ff_q <= ff_d; pend_q <= pend_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q <= op_i; id_q <= order_id_i; buy_q <= buy_side_i;
      mkt_q <= is_market_i; lim_q <= limit_price_i;
    end
    rem_q <= rem_d; ridx_q <= ridx_d;
    best_idx_q <= best_idx_d; free_idx_q <= free_idx_d;
    best_q <= best_d; best_age_q <= best_age_d;
    p_tid_q <= p_tid_d; p_price_q <= p_price_d; p_qty_q <= p_qty_d;
    p_buyer_q <= p_buyer_d; p_seller_q <= p_seller_d; p_left_q <= p_left_d;
    otv_q <= otv_d; olast_q <= olast_d; ost_q <= ost_d; otid_q <= otid_d;
    oprice_q <= oprice_d; oqty_q <= oqty_d; obuy_q <= obuy_d; osell_q <= osell_d;
    oleft_q <= oleft_d;
  end

  assign out_valid_o   = ov_q;
  assign status_o      = ost_q;
  assign trade_valid_o = otv_q;
  assign trade_id_o    = otid_q;
  assign trade_price_o = oprice_q;
  assign trade_qty_o   = oqty_q;
  assign buyer_id_o    = obuy_q;
  assign seller_id_o   = osell_q;
  assign left_qty_o    = oleft_q;
  assign last_o        = olast_q;

  a_trade_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && trade_valid_o |-> trade_qty_o != '0)
    else $error("trade with zero quantity");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o)
    else $error("input taken while busy");

  a_trade_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_TRADE |-> n_q < CW'(OrderSlots))
    else $error("trade count overrun");

endmodule

FILE: tb/sv/limit_order_matching_engine_test.sv
// Self-checking testbench for the limit order matching engine with a built-in book predictor.
module limit_order_matching_engine_test;
  import lome_pkg::*;

  localparam int Slots = DefOrderSlots;
  localparam int CycleLimit = 6000000;
  localparam int DrainCycles = 300;

  typedef struct {
    logic        op;
    logic [31:0] order_id;
    logic        buy_side;
    logic        is_market;
    logic [31:0] limit_price;
    logic [31:0] quantity;
  } order_t;

  typedef struct {
    logic [2:0]  status;
    logic        trade_valid;
    logic [63:0] trade_id;
    logic [31:0] trade_price;
    logic [31:0] trade_qty;
    logic [31:0] buyer_id;
    logic [31:0] seller_id;
    logic [31:0] left_qty;
    logic        last;
  } fill_t;

  typedef struct {
    order_t      ord;
    bit          typed;
    logic [2:0]  status;
    logic [31:0] left_qty;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        op_i = 1'b0;
  logic [31:0] order_id_i = '0;
  logic        buy_side_i = 1'b0;
  logic        is_market_i = 1'b0;
  logic [31:0] limit_price_i = '0;
  logic [31:0] quantity_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic        trade_valid_o;
  logic [63:0] trade_id_o;
  logic [31:0] trade_price_o;
  logic [31:0] trade_qty_o;
  logic [31:0] buyer_id_o;
  logic [31:0] seller_id_o;
  logic [31:0] left_qty_o;
  logic        last_o;

  limit_order_matching_engine dut (.*);

  always #5 clk_i = ~clk_i;

  bit          book_valid [Slots];
  bit          book_buy [Slots];
  logic [31:0] book_id [Slots];
  logic [31:0] book_price [Slots];
  logic [31:0] book_left [Slots];
  logic [31:0] book_seq [Slots];
  logic [31:0] seq_count = '0;
  logic [63:0] trade_count = '0;

  fill_t expected_fills [$];
  int    errors = 0;
  int    cycles = 0;
  bit    steady = 1'b0;
  int    out_stall = 0;

  function automatic int best_resting(bit want_buy);
    int best;
    bit better;
    best = -1;
    for (int i = 0; i < Slots; i++) begin
      if (!book_valid[i] || book_buy[i] != want_buy) continue;
      if (best < 0) begin
        best = i;
        continue;
      end
      if (book_price[i] != book_price[best])
        better = want_buy ? (book_price[i] > book_price[best]) : (book_price[i] < book_price[best]);
      else
        better = (seq_count - book_seq[i]) > (seq_count - book_seq[best]);
      if (better) best = i;
    end
    return best;
  endfunction

  function automatic void book_apply(order_t o);
    fill_t       f;
    int          b, hit, free, n;
    logic [31:0] rem, m;
    logic [2:0]  st;
    f = '{default: '0};
    if (o.op == OpCancel) begin
      hit = -1;
      for (int i = 0; i < Slots; i++) begin
        if (!book_valid[i] || book_id[i] != o.order_id) continue;
        if (hit < 0 || (seq_count - book_seq[i]) > (seq_count - book_seq[hit])) hit = i;
      end
      if (hit >= 0) book_valid[hit] = 1'b0;
      f.status = (hit >= 0) ? StatusCancel : StatusUnknown;
      f.last = 1'b1;
      expected_fills.insert(expected_fills.size(), f);
      return;
    end
    seq_count++;
    rem = o.quantity;
    n = 0;
    st = StatusDone;
    while (rem > 0 && n < Slots) begin
      b = best_resting(!o.buy_side);
      if (b < 0) break;
      if (!o.is_market && (o.buy_side ? (o.limit_price < book_price[b])
                                       : (o.limit_price > book_price[b]))) break;
      m = (rem < book_left[b]) ? rem : book_left[b];
      rem -= m;
      book_left[b] -= m;
      if (book_left[b] == 0) book_valid[b] = 1'b0;
      f = '{default: '0};
      f.trade_valid = 1'b1;
      f.trade_id = trade_count;
      f.trade_price = book_price[b];
      f.trade_qty = m;
      f.buyer_id = o.buy_side ? o.order_id : book_id[b];
      f.seller_id = o.buy_side ? book_id[b] : o.order_id;
      f.left_qty = rem;
      expected_fills.insert(expected_fills.size(), f);
      trade_count++;
      n++;
    end
    if (rem > 0 && !o.is_market) begin
      free = -1;
      for (int i = 0; i < Slots; i++) begin
        if (!book_valid[i]) begin
          free = i;
          break;
        end
      end
      if (free >= 0) begin
        book_valid[free] = 1'b1;
        book_buy[free] = o.buy_side;
        book_id[free] = o.order_id;
        book_price[free] = o.limit_price;
        book_left[free] = rem;
        book_seq[free] = seq_count;
        st = StatusRested;
      end else begin
        st = StatusFull;
      end
    end
    if (n == 0) begin
      f = '{default: '0};
      f.left_qty = rem;
      expected_fills.insert(expected_fills.size(), f);
    end
    expected_fills[$].status = st;
    expected_fills[$].last = 1'b1;
  endfunction

  task automatic send_order(order_t o);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= o.op;
    order_id_i <= o.order_id;
    buy_side_i <= o.buy_side;
    is_market_i <= o.is_market;
    limit_price_i <= o.limit_price;
    quantity_i <= o.quantity;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_row(row_t r);
    int depth;
    fill_t f;
    send_order(r.ord);
    depth = expected_fills.size();
    book_apply(r.ord);
    if (r.typed) begin
      while (expected_fills.size() > depth) expected_fills.delete(expected_fills.size() - 1);
      f = '{default: '0};
      f.status = r.status;
      f.left_qty = r.left_qty;
      f.last = 1'b1;
      expected_fills.insert(expected_fills.size(), f);
    end
  endtask

  function automatic order_t mk(logic op, logic [31:0] id, logic buy, logic mkt,
                                logic [31:0] price, logic [31:0] qty);
    order_t o;
    o = '{op, id, buy, mkt, price, qty};
    return o;
  endfunction

  function automatic order_t random_order();
    order_t o;
    int     pick;
    pick = $urandom_range(0, 99);
    o.op = (pick < 18) ? OpCancel : OpAdd;
    o.order_id = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 15);
    o.buy_side = 1'($urandom_range(0, 1));
    o.is_market = ($urandom_range(0, 5) == 0);
    o.limit_price = ($urandom_range(0, 14) == 0) ? $urandom : 1000 + $urandom_range(0, 10);
    case ($urandom_range(0, 19))
      0: o.quantity = 0;
      1: o.quantity = $urandom;
      default: o.quantity = $urandom_range(1, 20);
    endcase
    if (pick == 99) begin
      o.op = OpAdd;
      o.is_market = 1'b1;
      o.quantity = $urandom;
    end
    return o;
  endfunction

  always @(posedge clk_i) begin
    fill_t e;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("limit_order_matching_engine_test NOT OK");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_fills.size() == 0) begin
        $error("unexpected result, status %0d", status_o);
        errors++;
      end else begin
        e = expected_fills[0];
        expected_fills.delete(0);
        if (status_o !== e.status) begin
          $error("status exp %0d got %0d", e.status, status_o); errors++;
        end
        if (trade_valid_o !== e.trade_valid) begin
          $error("trade_valid exp %0d got %0d", e.trade_valid, trade_valid_o); errors++;
        end
        if (trade_id_o !== e.trade_id) begin
          $error("trade_id exp %0d got %0d", e.trade_id, trade_id_o); errors++;
        end
        if (trade_price_o !== e.trade_price) begin
          $error("trade_price exp %0d got %0d", e.trade_price, trade_price_o); errors++;
        end
        if (trade_qty_o !== e.trade_qty) begin
          $error("trade_qty exp %0d got %0d", e.trade_qty, trade_qty_o); errors++;
        end
        if (buyer_id_o !== e.buyer_id) begin
          $error("buyer_id exp %0d got %0d", e.buyer_id, buyer_id_o); errors++;
        end
        if (seller_id_o !== e.seller_id) begin
          $error("seller_id exp %0d got %0d", e.seller_id, seller_id_o); errors++;
        end
        if (left_qty_o !== e.left_qty) begin
          $error("left_qty exp %0d got %0d", e.left_qty, left_qty_o); errors++;
        end
        if (last_o !== e.last) begin
          $error("last exp %0d got %0d", e.last, last_o); errors++;
        end
      end
      out_stall = steady ? 0 : $urandom_range(0, 3);
      out_ready_i <= (out_stall == 0);
    end else if (rst_ni) begin
      if (out_stall > 0) out_stall--;
      out_ready_i <= (out_stall == 0);
    end
  end

  row_t directed [] = '{
    '{mk(OpCancel, 32'd5, 1'b0, 1'b0, 32'd0, 32'd0), 1'b1, StatusUnknown, 32'd0},
    '{mk(OpAdd, 32'd1, 1'b1, 1'b0, 32'd100, 32'd10), 1'b1, StatusRested, 32'd10},
    '{mk(OpAdd, 32'd2, 1'b1, 1'b0, 32'd100, 32'd5), 1'b1, StatusRested, 32'd5},
    '{mk(OpAdd, 32'd3, 1'b0, 1'b1, 32'd0, 32'd12), 1'b0, StatusDone, 32'd0},
    '{mk(OpAdd, 32'hFFFFFFFF, 1'b0, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF), 1'b1,
      StatusRested, 32'hFFFFFFFF},
    '{mk(OpAdd, 32'd5, 1'b1, 1'b1, 32'd0, 32'd0), 1'b1, StatusDone, 32'd0},
    '{mk(OpAdd, 32'd6, 1'b1, 1'b0, 32'hFFFFFFFF, 32'd7), 1'b0, StatusDone, 32'd0},
    '{mk(OpCancel, 32'hFFFFFFFF, 1'b0, 1'b0, 32'd0, 32'd0), 1'b1, StatusCancel, 32'd0},
    '{mk(OpAdd, 32'd7, 1'b1, 1'b1, 32'hFFFFFFFF, 32'd3), 1'b1, StatusDone, 32'd3},
    '{mk(OpAdd, 32'd9, 1'b0, 1'b0, 32'd50, 32'd1), 1'b0, StatusDone, 32'd0},
    '{mk(OpAdd, 32'd9, 1'b0, 1'b0, 32'd50, 32'd1), 1'b0, StatusDone, 32'd0},
    '{mk(OpCancel, 32'd9, 1'b0, 1'b0, 32'd0, 32'd0), 1'b1, StatusUnknown, 32'd0},
    '{mk(OpAdd, 32'd0, 1'b1, 1'b0, 32'd0, 32'd4), 1'b0, StatusDone, 32'd0},
    '{mk(OpAdd, 32'd11, 1'b0, 1'b0, 32'd0, 32'd2), 1'b0, StatusDone, 32'd0},
    '{mk(OpAdd, 32'd12, 1'b0, 1'b0, 32'd200, 32'd8), 1'b0, StatusDone, 32'd0},
    '{mk(OpAdd, 32'd13, 1'b1, 1'b0, 32'd250, 32'd20), 1'b0, StatusDone, 32'd0},
    '{mk(OpCancel, 32'd77, 1'b1, 1'b1, 32'd9, 32'd9), 1'b1, StatusUnknown, 32'd0},
    '{mk(OpAdd, 32'hAAAA5555, 1'b0, 1'b1, 32'd0, 32'hFFFFFFFF), 1'b0, StatusDone, 32'd0},
    '{mk(OpAdd, 32'h5555AAAA, 1'b1, 1'b1, 32'd0, 32'hFFFFFFFF), 1'b0, StatusDone, 32'd0}
  };

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    out_ready_i <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send_row(directed[i]);
    // fill the store, overflow it, then sweep it in one order
    for (int i = 0; i < Slots + 2; i++)
      send_row('{mk(OpAdd, 32'd100 + i, 1'b1, 1'b0, 32'd1, 32'd1), 1'b0, StatusDone, 32'd0});
    send_row('{mk(OpAdd, 32'd500, 1'b0, 1'b1, 32'd0, 32'd1000), 1'b0, StatusDone, 32'd0});
    for (int i = 0; i < 194; i++) begin
      if (i % 40 == 0) steady = ($urandom_range(0, 2) == 0);
      if (i == 140) begin
        in_valid_i <= 1'b0;
        while (expected_fills.size() != 0) @(posedge clk_i);
      end
      send_row('{random_order(), 1'b0, StatusDone, 32'd0});
    end
    in_valid_i <= 1'b0;
    while (expected_fills.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("limit_order_matching_engine_test OK");
    end else begin
      $display("limit_order_matching_engine_test NOT OK");
    end
    $finish;
  end
endmodule

FILE: limit_order_matching_engine.f
design/lome_pkg.sv
design/lome_store.sv
design/limit_order_matching_engine.sv
tb/sv/limit_order_matching_engine_test.sv
